// ===== rtl/core/pbp_pkg.sv =====
// Shared types, constants and helper functions of the polarisation bearing pair core.
package pbp_pkg;

    // Fixed-point format: Q2.30 components, Q30 internal bearing terms
    localparam int FRAC_BITS   = 30;
    localparam int Q_SHIFT     = 30;
    localparam int OUT_SHIFT   = 2 * Q_SHIFT - FRAC_BITS;
    localparam int TOL_W       = 21;
    localparam int ADDR_W      = 4;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int DIV_LANES   = 5;

    localparam logic signed [31:0] ONE = 32'sd1073741824;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_REF_X,
        REG_REF_Y,
        REG_REF_Z,
        REG_TOL
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic               last;
    } t_item;

    typedef struct packed {
        logic signed [31:0] ref_cos2;
        logic signed [31:0] ref_sin2;
        logic signed [31:0] far_cos2;
        logic signed [31:0] far_sin2;
        logic               last_out;
    } t_result;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_cross;

    // Per-request data that rides alongside the square-root and divider stages
    typedef struct packed {
        logic   tag;
        t_vec   a;
        t_cross e;
        logic   par;
        logic   pol;
        logic   pol_neg;
    } t_side;

    // Clamp a wide value to [-ONE, ONE]
    function automatic logic signed [31:0] sat_one(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(ONE);
        lo = -hi;
        if (v > hi) begin
            return ONE;
        end else if (v < lo) begin
            return -ONE;
        end
        return v[31:0];
    endfunction

    // Clamp a 32-bit component to [-ONE, ONE]
    function automatic logic signed [31:0] sat_comp(input logic signed [31:0] v);
        if (v > ONE) begin
            return ONE;
        end else if (v < -ONE) begin
            return -ONE;
        end
        return v;
    endfunction

    // True when a magnitude lies strictly within the tolerance of one
    function automatic logic near_one(input logic signed [63:0] mag,
                                      input logic [TOL_W-1:0] tol);
        logic signed [63:0] d;
        logic signed [63:0] t;
        d = mag - 64'(ONE);
        t = $signed({{(64-TOL_W){1'b0}}, tol});
        if (d < 0) begin
            d = -d;
        end
        return d < t;
    endfunction

endpackage

// ===== rtl/core/pbp_kernel.sv =====
// Pipelined double-angle bearing kernel: origin vector a, target vector b.
module pbp_kernel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_tag,
    input  pbp_pkg::t_vec              i_a,
    input  pbp_pkg::t_vec              i_b,
    input  logic [pbp_pkg::TOL_W-1:0]  i_tol,
    output logic                       o_valid,
    output logic                       o_tag,
    output logic signed [31:0]         o_cos2,
    output logic signed [31:0]         o_sin2
);
    import pbp_pkg::*;

    localparam int SQ_LAST = SQRT_STAGES - 1;
    localparam int DV_LAST = DIV_STAGES - 1;

    // ---------------- stage 1: products ----------------
    logic               r_s1_v;
    logic               r_s1_tag;
    t_vec               r_s1_a;
    logic signed [63:0] r_s1_dot [3];
    logic signed [63:0] r_s1_cr  [6];
    logic signed [63:0] r_s1_sq  [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
        end
    end

    // Form dot, cross and planar-norm products
    always_ff @(posedge i_clk) begin
        r_s1_tag    <= i_tag;
        r_s1_a      <= i_a;
        r_s1_dot[0] <= 64'(i_a.x) * 64'(i_b.x);
        r_s1_dot[1] <= 64'(i_a.y) * 64'(i_b.y);
        r_s1_dot[2] <= 64'(i_a.z) * 64'(i_b.z);
        r_s1_cr[0]  <= 64'(i_a.y) * 64'(i_b.z);
        r_s1_cr[1]  <= 64'(i_a.z) * 64'(i_b.y);
        r_s1_cr[2]  <= 64'(i_a.z) * 64'(i_b.x);
        r_s1_cr[3]  <= 64'(i_a.x) * 64'(i_b.z);
        r_s1_cr[4]  <= 64'(i_a.x) * 64'(i_b.y);
        r_s1_cr[5]  <= 64'(i_a.y) * 64'(i_b.x);
        r_s1_sq[0]  <= 64'(i_a.x) * 64'(i_a.x);
        r_s1_sq[1]  <= 64'(i_a.y) * 64'(i_a.y);
    end

    // ---------------- stage 2: sums ----------------
    logic               r_s2_v;
    logic               r_s2_tag;
    t_vec               r_s2_a;
    logic signed [63:0] r_s2_dot;
    t_cross             r_s2_e;
    logic [63:0]        r_s2_n2sq;
    logic signed [63:0] n_cx;
    logic signed [63:0] n_cy;
    logic signed [63:0] n_cz;

    always_comb begin
        n_cx = (r_s1_cr[0] - r_s1_cr[1]) >>> Q_SHIFT;
        n_cy = (r_s1_cr[2] - r_s1_cr[3]) >>> Q_SHIFT;
        n_cz = (r_s1_cr[4] - r_s1_cr[5]) >>> Q_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_tag  <= r_s1_tag;
        r_s2_a    <= r_s1_a;
        r_s2_dot  <= r_s1_dot[0] + r_s1_dot[1] + r_s1_dot[2];
        r_s2_e.x  <= n_cx[32:0];
        r_s2_e.y  <= n_cy[32:0];
        r_s2_e.z  <= n_cz[32:0];
        r_s2_n2sq <= $unsigned(r_s1_sq[0] + r_s1_sq[1]);
    end

    // ---------------- stage 3: special cases and cross squares ----------------
    logic               r_s3_v;
    t_side              r_s3_side;
    logic [63:0]        r_s3_sq [3];
    logic [63:0]        r_s3_n2sq;
    logic signed [63:0] n_m;
    logic signed [63:0] n_az;

    always_comb begin
        n_m  = r_s2_dot >>> FRAC_BITS;
        if (n_m < 0) begin
            n_m = -n_m;
        end
        n_az = 64'(r_s2_a.z);
        if (n_az < 0) begin
            n_az = -n_az;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_side.tag     <= r_s2_tag;
        r_s3_side.a       <= r_s2_a;
        r_s3_side.e       <= r_s2_e;
        r_s3_side.par     <= near_one(n_m, i_tol);
        r_s3_side.pol     <= near_one(n_az, i_tol);
        r_s3_side.pol_neg <= (r_s2_a.z >= 0);
        r_s3_sq[0]        <= $unsigned(64'(r_s2_e.x) * 64'(r_s2_e.x));
        r_s3_sq[1]        <= $unsigned(64'(r_s2_e.y) * 64'(r_s2_e.y));
        r_s3_sq[2]        <= $unsigned(64'(r_s2_e.z) * 64'(r_s2_e.z));
        r_s3_n2sq         <= r_s2_n2sq;
    end

    // ---------------- stage 4: cross norm squared ----------------
    logic        r_s4_v;
    t_side       r_s4_side;
    logic [63:0] r_s4_nsq [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_side   <= r_s3_side;
        r_s4_nsq[0] <= r_s3_sq[0] + r_s3_sq[1] + r_s3_sq[2];
        r_s4_nsq[1] <= r_s3_n2sq;
    end

    // ---------------- square roots: one root bit per stage, two lanes ----------------
    logic        r_sq_v    [SQRT_STAGES];
    t_side       r_sq_side [SQRT_STAGES];
    logic [63:0] r_sq_rad  [2][SQRT_STAGES];
    logic [35:0] r_sq_rem  [2][SQRT_STAGES];
    logic [31:0] r_sq_root [2][SQRT_STAGES];

    genvar k, l;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_sq
            logic  v_in;
            t_side side_in;

            if (k == 0) begin : g_src
                assign v_in    = r_s4_v;
                assign side_in = r_s4_side;
            end else begin : g_src
                assign v_in    = r_sq_v[k-1];
                assign side_in = r_sq_side[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_v[k] <= 1'b0;
                end else begin
                    r_sq_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_sq_side[k] <= side_in;
            end

            for (l = 0; l < 2; l++) begin : g_lane
                logic [63:0] rad_in;
                logic [35:0] rem_in;
                logic [31:0] root_in;
                logic [35:0] rem_sh;
                logic [35:0] trial;
                logic        ge;

                if (k == 0) begin : g_init
                    assign rad_in  = r_s4_nsq[l];
                    assign rem_in  = '0;
                    assign root_in = '0;
                end else begin : g_init
                    assign rad_in  = r_sq_rad[l][k-1];
                    assign rem_in  = r_sq_rem[l][k-1];
                    assign root_in = r_sq_root[l][k-1];
                end

                // Bring down two radicand bits and try the next root bit
                always_comb begin
                    rem_sh = {rem_in[33:0], rad_in[63:62]};
                    trial  = {2'b00, root_in, 2'b01};
                    ge     = (rem_sh >= trial);
                end

                always_ff @(posedge i_clk) begin
                    r_sq_rad[l][k]  <= {rad_in[61:0], 2'b00};
                    r_sq_rem[l][k]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_sq_root[l][k] <= {root_in[30:0], ge};
                end
            end
        end
    endgenerate

    // ---------------- divisions: one quotient bit per stage, five lanes ----------------
    logic        r_dv_v    [DIV_STAGES];
    t_side       r_dv_side [DIV_STAGES];
    logic [31:0] r_dv_den  [2][DIV_STAGES];
    logic [31:0] r_dv_rem  [DIV_LANES][DIV_STAGES];
    logic [30:0] r_dv_low  [DIV_LANES][DIV_STAGES];
    logic [30:0] r_dv_q    [DIV_LANES][DIV_STAGES];
    logic        r_dv_neg  [DIV_LANES][DIV_STAGES];

    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_dv
            logic        v_in;
            t_side       side_in;
            logic [31:0] den_in [2];

            if (k == 0) begin : g_src
                assign v_in      = r_sq_v[SQ_LAST];
                assign side_in   = r_sq_side[SQ_LAST];
                assign den_in[0] = r_sq_root[0][SQ_LAST];
                assign den_in[1] = r_sq_root[1][SQ_LAST];
            end else begin : g_src
                assign v_in      = r_dv_v[k-1];
                assign side_in   = r_dv_side[k-1];
                assign den_in[0] = r_dv_den[0][k-1];
                assign den_in[1] = r_dv_den[1][k-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[k] <= 1'b0;
                end else begin
                    r_dv_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_dv_side[k]   <= side_in;
                r_dv_den[0][k] <= den_in[0];
                r_dv_den[1][k] <= den_in[1];
            end

            for (l = 0; l < DIV_LANES; l++) begin : g_lane
                logic [31:0] rem_in;
                logic [30:0] low_in;
                logic [30:0] q_in;
                logic        neg_in;
                logic [31:0] d;
                logic [32:0] rem_sh;
                logic        ge;

                assign d = (l < 3) ? den_in[0] : den_in[1];

                if (k == 0) begin : g_init
                    logic signed [32:0] num;
                    logic signed [32:0] mag;

                    // Pick the numerator; quotient bits above bit 30 are known zero
                    always_comb begin
                        unique case (l)
                            0:       num = side_in.e.x;
                            1:       num = side_in.e.y;
                            2:       num = side_in.e.z;
                            3:       num = 33'(side_in.a.y);
                            default: num = -33'(side_in.a.x);
                        endcase
                        mag = (num < 0) ? -num : num;
                    end

                    assign neg_in = num[32];
                    assign rem_in = {1'b0, mag[31:1]};
                    assign low_in = {mag[0], 30'b0};
                    assign q_in   = '0;
                end else begin : g_init
                    assign neg_in = r_dv_neg[l][k-1];
                    assign rem_in = r_dv_rem[l][k-1];
                    assign low_in = r_dv_low[l][k-1];
                    assign q_in   = r_dv_q[l][k-1];
                end

                // Shift in one dividend bit and subtract the divisor where it fits
                always_comb begin
                    rem_sh = {rem_in, low_in[30]};
                    ge     = (rem_sh >= {1'b0, d});
                end

                always_ff @(posedge i_clk) begin
                    r_dv_rem[l][k] <= ge ? 32'(rem_sh - {1'b0, d}) : rem_sh[31:0];
                    r_dv_low[l][k] <= {low_in[29:0], 1'b0};
                    r_dv_q[l][k]   <= {q_in[29:0], ge};
                    r_dv_neg[l][k] <= neg_in;
                end
            end
        end
    endgenerate

    // ---------------- U: signed unit vectors ----------------
    logic               r_u_v;
    t_side              r_u_side;
    logic signed [31:0] r_u [DIV_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else begin
            r_u_v <= r_dv_v[DV_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_side <= r_dv_side[DV_LAST];
    end

    // Apply the numerator sign; a zero norm gives a zero vector
    generate
        for (l = 0; l < DIV_LANES; l++) begin : g_u
            logic [31:0]        d;
            logic signed [31:0] q;

            assign d = (l < 3) ? r_dv_den[0][DV_LAST] : r_dv_den[1][DV_LAST];
            assign q = $signed({1'b0, r_dv_q[l][DV_LAST]});

            always_ff @(posedge i_clk) begin
                if (d == '0) begin
                    r_u[l] <= '0;
                end else begin
                    r_u[l] <= r_dv_neg[l][DV_LAST] ? -q : q;
                end
            end
        end
    endgenerate

    // ---------------- P1: unit-vector products ----------------
    logic               r_p1_v;
    t_side              r_p1_side;
    logic signed [63:0] r_p1_m [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= r_u_v;
        end
    end

    // Lanes: 0 u1x, 1 u1y, 2 u1z, 3 u2x, 4 u2y
    always_ff @(posedge i_clk) begin
        r_p1_side <= r_u_side;
        r_p1_m[0] <= 64'(r_u[2]) * 64'(r_u[4]);
        r_p1_m[1] <= 64'(r_u[2]) * 64'(r_u[3]);
        r_p1_m[2] <= 64'(r_u[0]) * 64'(r_u[4]);
        r_p1_m[3] <= 64'(r_u[1]) * 64'(r_u[3]);
        r_p1_m[4] <= 64'(r_u[0]) * 64'(r_u[3]);
        r_p1_m[5] <= 64'(r_u[1]) * 64'(r_u[4]);
    end

    // ---------------- P2: rescale to Q30 ----------------
    logic               r_p2_v;
    t_side              r_p2_side;
    logic signed [32:0] r_p2_t [3];
    logic signed [31:0] r_p2_c;
    logic signed [63:0] n_t1;
    logic signed [63:0] n_t2;
    logic signed [63:0] n_t3;

    always_comb begin
        n_t1 = -(r_p1_m[0] >>> Q_SHIFT);
        n_t2 = r_p1_m[1] >>> Q_SHIFT;
        n_t3 = (r_p1_m[2] - r_p1_m[3]) >>> Q_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_side <= r_p1_side;
        r_p2_t[0] <= n_t1[32:0];
        r_p2_t[1] <= n_t2[32:0];
        r_p2_t[2] <= n_t3[32:0];
        r_p2_c    <= sat_one((r_p1_m[4] + r_p1_m[5]) >>> Q_SHIFT);
    end

    // ---------------- P3: sine numerator products ----------------
    logic               r_p3_v;
    t_side              r_p3_side;
    logic signed [63:0] r_p3_n [3];
    logic signed [31:0] r_p3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3_side <= r_p2_side;
        r_p3_c    <= r_p2_c;
        r_p3_n[0] <= 64'(r_p2_side.a.x) * 64'(r_p2_t[0]);
        r_p3_n[1] <= 64'(r_p2_side.a.y) * 64'(r_p2_t[1]);
        r_p3_n[2] <= 64'(r_p2_side.a.z) * 64'(r_p2_t[2]);
    end

    // ---------------- P4: select case, fold sine non-negative ----------------
    logic               r_p4_v;
    logic               r_p4_tag;
    logic signed [31:0] r_p4_c;
    logic signed [31:0] r_p4_s;
    logic signed [31:0] n_c;
    logic signed [31:0] n_s;

    always_comb begin
        n_s = sat_one((r_p3_n[0] + r_p3_n[1] + r_p3_n[2]) >>> FRAC_BITS);
        n_c = r_p3_c;
        priority if (r_p3_side.par) begin
            n_c = ONE;
            n_s = '0;
        end else if (r_p3_side.pol) begin
            n_c = r_p3_side.pol_neg ? -ONE : ONE;
            n_s = '0;
        end
        if (n_s < 0) begin
            n_c = -n_c;
            n_s = -n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p4_tag <= r_p3_side.tag;
        r_p4_c   <= n_c;
        r_p4_s   <= n_s;
    end

    // ---------------- P5: double-angle products ----------------
    logic               r_p5_v;
    logic               r_p5_tag;
    logic signed [63:0] r_p5_cc;
    logic signed [63:0] r_p5_ss;
    logic signed [63:0] r_p5_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_v <= 1'b0;
        end else begin
            r_p5_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p5_tag <= r_p4_tag;
        r_p5_cc  <= 64'(r_p4_c) * 64'(r_p4_c);
        r_p5_ss  <= 64'(r_p4_s) * 64'(r_p4_s);
        r_p5_cs  <= 64'(r_p4_c) * 64'(r_p4_s);
    end

    // ---------------- P6: rescale and clamp results ----------------
    logic               r_p6_v;
    logic               r_p6_tag;
    logic signed [31:0] r_p6_c2;
    logic signed [31:0] r_p6_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_v <= 1'b0;
        end else begin
            r_p6_v <= r_p5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p6_tag <= r_p5_tag;
        r_p6_c2  <= sat_one((r_p5_cc - r_p5_ss) >>> OUT_SHIFT);
        r_p6_s2  <= sat_one((r_p5_cs <<< 1) >>> OUT_SHIFT);
    end

    assign o_valid = r_p6_v;
    assign o_tag   = r_p6_tag;
    assign o_cos2  = r_p6_c2;
    assign o_sin2  = r_p6_s2;

endmodule

// ===== rtl/core/polarization_bearing_pair_core.sv =====
// Top level of the polarisation bearing pair core: register port, input stage, two kernels.
//
// One request is taken on every clock edge at which start is high; busy never rises.
// Each request yields one result, marked by o_valid for a single cycle, in request
// order. The latency is set by the two bit-serial units in each kernel: a 32-stage
// square root and a 31-stage divider, plus eleven kernel stages of products around
// them and the input and output registers. The receiver cannot stall the result
// stream. Write the reference vector and tolerance only while no request is in
// flight.
module polarization_bearing_pair_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pbp_pkg::t_item               i_item,
    output logic                         o_valid,
    output pbp_pkg::t_result             o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pbp_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_ref_x;
    logic signed [31:0] r_ref_y;
    logic signed [31:0] r_ref_z;
    logic [TOL_W-1:0]   r_tol;
    logic               n_wr;
    t_reg_idx           n_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel & penable & pwrite;
    assign n_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= ONE;
            r_ref_y <= '0;
            r_ref_z <= '0;
            r_tol   <= TOL_W'(2);
        end else if (n_wr) begin
            unique case (n_idx)
                REG_REF_X: r_ref_x <= pwdata;
                REG_REF_Y: r_ref_y <= pwdata;
                REG_REF_Z: r_ref_z <= pwdata;
                REG_TOL:   r_tol   <= pwdata[TOL_W-1:0];
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (n_idx)
            REG_REF_X: prdata = r_ref_x;
            REG_REF_Y: prdata = r_ref_y;
            REG_REF_Z: prdata = r_ref_z;
            REG_TOL:   prdata = {{(32-TOL_W){1'b0}}, r_tol};
        endcase
    end

    // ---------------- input stage: clamp components ----------------
    logic r_in_v;
    logic r_in_last;
    t_vec r_pt;
    t_vec r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_last <= i_item.last;
        r_pt.x    <= sat_comp(i_item.pt_x);
        r_pt.y    <= sat_comp(i_item.pt_y);
        r_pt.z    <= sat_comp(i_item.pt_z);
        r_ref.x   <= sat_comp(r_ref_x);
        r_ref.y   <= sat_comp(r_ref_y);
        r_ref.z   <= sat_comp(r_ref_z);
    end

    // ---------------- kernels: bearing at reference and at point ----------------
    logic               k0_valid;
    logic               k0_tag;
    logic signed [31:0] k0_cos2;
    logic signed [31:0] k0_sin2;
    logic signed [31:0] k1_cos2;
    logic signed [31:0] k1_sin2;

    pbp_kernel u_ref_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_tag   (r_in_last),
        .i_a     (r_ref),
        .i_b     (r_pt),
        .i_tol   (r_tol),
        .o_valid (k0_valid),
        .o_tag   (k0_tag),
        .o_cos2  (k0_cos2),
        .o_sin2  (k0_sin2)
    );

    pbp_kernel u_far_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_tag   (r_in_last),
        .i_a     (r_pt),
        .i_b     (r_ref),
        .i_tol   (r_tol),
        .o_valid (),
        .o_tag   (),
        .o_cos2  (k1_cos2),
        .o_sin2  (k1_sin2)
    );

    // ---------------- output register ----------------
    logic    r_out_v;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= k0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.ref_cos2 <= k0_cos2;
        r_out.ref_sin2 <= k0_sin2;
        r_out.far_cos2 <= k1_cos2;
        r_out.far_sin2 <= k1_sin2;
        r_out.last_out <= k0_tag;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule
